FILE: rtl/fccw_pkg.sv
// shared types, constants and codes of the fat12 cluster chain sector walker
`default_nettype none

package fccw_pkg;

    // fat byte store
    localparam int FAT_BYTES = 8192;
    localparam int FAT_AW    = 13;

    // field and word widths
    localparam int LBA_W      = 32;
    localparam int CLUSTER_W  = 12;
    localparam int SECTOR_W   = 8;
    localparam int FAT_IDX_W  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 2;

    // root directory length divider
    localparam int DIV_W     = 22;
    localparam int DIVISOR_W = 13;
    localparam int DIV_CNT_W = 5;

    // fat entry decoding
    localparam logic [CLUSTER_W-1:0] END_MARK   = 12'hFF8;
    localparam logic [15:0]          ENTRY_MASK = 16'h0FFF;

    // register reset values
    localparam logic [15:0] RST_RESERVED_SECTORS = 16'd1;
    localparam logic [15:0] RST_SECTORS_PER_FAT  = 16'd9;
    localparam logic [7:0]  RST_FAT_COPIES       = 8'd2;
    localparam logic [15:0] RST_ROOT_ENTRIES     = 16'd224;
    localparam logic [12:0] RST_BYTES_PER_SECTOR = 13'd512;
    localparam logic [7:0]  RST_SECTORS_PER_CLUS = 8'd1;

    // item operations
    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_OPEN_FILE = 2'd1,
        OP_OPEN_ROOT = 2'd2,
        OP_ADVANCE   = 2'd3
    } opcode_t;

    // result status codes
    typedef enum logic [1:0] {
        RS_SECTOR = 2'd0,
        RS_END    = 2'd1,
        RS_LOADED = 2'd2
    } resp_status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESERVED_SECTORS = 3'd0,
        CFG_SECTORS_PER_FAT  = 3'd1,
        CFG_FAT_COPIES       = 3'd2,
        CFG_ROOT_ENTRIES     = 3'd3,
        CFG_BYTES_PER_SECTOR = 3'd4,
        CFG_SECTORS_PER_CLUS = 3'd5
    } cfg_index_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC_MUL,
        S_CALC_ROOT,
        S_CALC_DIV,
        S_CALC_DATA,
        S_FAT_RD0,
        S_FAT_RD1,
        S_ENTRY,
        S_CHECK,
        S_MUL,
        S_SUM,
        S_RESP
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic calc_start;
        logic calc_root;
        logic calc_data;
        logic fat_rd0;
        logic fat_rd1;
        logic entry_take;
        logic end_check;
        logic mul_take;
        logic sum_take;
        logic resp_load;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic dirty;
        logic wrap;
        logic root_mode;
        logic chain_ended;
        logic pos_end;
        logic div_done;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/fccw_div.sv
// iterative restoring divider for the root directory sector count
`default_nettype none

module fccw_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [fccw_pkg::DIV_W-1:0]     dividend,
    input  wire logic [fccw_pkg::DIVISOR_W-1:0] divisor,
    output logic                                done,
    output logic [fccw_pkg::DIV_W-1:0]          quotient
);
    import fccw_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  count_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIV_W-1:0]      quo_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic                  zero_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVISOR_W:0]    trial_sub;

    // one quotient bit per cycle
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign fits      = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    // sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= DIV_CNT_W'(DIV_W - 1);
        end else if (busy_reg) begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            div_reg  <= divisor;
            zero_reg <= divisor == '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : quo_reg;

    // checks
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && count_reg == '0 && !start |=> done_reg)
        else $error("divider missed done");
    a_count_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && count_reg != '0 && !start |=> busy_reg)
        else $error("divider stopped early");

endmodule

`default_nettype wire

FILE: rtl/fccw_ctrl.sv
// controller state machine of the cluster chain sector walker
`default_nettype none

module fccw_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic [fccw_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               s_tready,
    input  wire fccw_pkg::dp_sts_t             sts,
    output fccw_pkg::ctrl_cmd_t                cmd
);
    import fccw_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    opcode_t op;

    assign op = opcode_t'(s_tuser);

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (sts.dirty) begin
                    state_next = S_CALC_MUL;
                end else if (s_tvalid) begin
                    unique case (op)
                        OP_LOAD:      state_next = S_RESP;
                        OP_OPEN_FILE: state_next = S_MUL;
                        OP_OPEN_ROOT: state_next = S_RESP;
                        OP_ADVANCE: begin
                            priority if (sts.root_mode || sts.chain_ended) begin
                                state_next = S_RESP;
                            end else if (sts.wrap) begin
                                state_next = S_FAT_RD0;
                            end else begin
                                state_next = S_CHECK;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CALC_MUL:  state_next = S_CALC_ROOT;
            S_CALC_ROOT: state_next = S_CALC_DIV;
            S_CALC_DIV:  state_next = sts.div_done ? S_CALC_DATA : S_CALC_DIV;
            S_CALC_DATA: state_next = S_IDLE;
            S_FAT_RD0:   state_next = S_FAT_RD1;
            S_FAT_RD1:   state_next = S_ENTRY;
            S_ENTRY:     state_next = S_CHECK;
            S_CHECK:     state_next = sts.pos_end ? S_RESP : S_MUL;
            S_MUL:       state_next = S_SUM;
            S_SUM:       state_next = S_RESP;
            S_RESP:      state_next = sts.out_free ? S_IDLE : S_RESP;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = !sts.dirty;
                cmd.accept = s_tvalid && !sts.dirty;
            end
            S_CALC_MUL:  cmd.calc_start = 1'b1;
            S_CALC_ROOT: cmd.calc_root  = 1'b1;
            S_CALC_DIV:  cmd            = '0;
            S_CALC_DATA: cmd.calc_data  = 1'b1;
            S_FAT_RD0:   cmd.fat_rd0    = 1'b1;
            S_FAT_RD1:   cmd.fat_rd1    = 1'b1;
            S_ENTRY:     cmd.entry_take = 1'b1;
            S_CHECK:     cmd.end_check  = 1'b1;
            S_MUL:       cmd.mul_take   = 1'b1;
            S_SUM:       cmd.sum_take   = 1'b1;
            S_RESP:      cmd.resp_load  = sts.out_free;
            default:     cmd            = '0;
        endcase
    end

    // checks
    a_no_accept_stale: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !sts.dirty && state_reg == S_IDLE)
        else $error("item taken with stale derived lba");
    a_resp_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.resp_load |=> state_reg == S_IDLE)
        else $error("result loaded without returning to idle");
    a_calc_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.calc_start |-> !s_tready)
        else $error("ready during recompute");

endmodule

`default_nettype wire

FILE: rtl/fccw_datapath.sv
// datapath: config registers, fat store, chain position and lba arithmetic
`default_nettype none

module fccw_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [fccw_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [fccw_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic [fccw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [fccw_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fccw_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [fccw_pkg::M_TUSER_W-1:0]       m_tuser,
    input  wire fccw_pkg::ctrl_cmd_t             cmd,
    output fccw_pkg::dp_sts_t                    sts
);
    import fccw_pkg::*;

    // configuration
    logic [15:0]          reserved_reg;
    logic [15:0]          spf_reg;
    logic [7:0]           copies_reg;
    logic [15:0]          root_entries_reg;
    logic [12:0]          bps_reg;
    logic [7:0]           spc_reg;
    logic                 dirty_reg;

    // derived lba values
    logic [23:0]          fat_mul_reg;
    logic [LBA_W-1:0]     root_lba_reg;
    logic [LBA_W-1:0]     data_lba_reg;
    logic [DIV_W-1:0]     dividend;
    logic                 div_done;
    logic [DIV_W-1:0]     quotient;

    // chain position
    logic [LBA_W-1:0]     pos_reg;
    logic [SECTOR_W-1:0]  sic_reg;
    logic                 root_mode_reg;
    logic                 chain_ended_reg;
    logic [SECTOR_W:0]    sic_inc;
    logic                 wrap;
    logic [LBA_W-1:0]     pos_inc;
    logic                 pos_end;

    // fat store
    logic [7:0]           fat_mem [FAT_BYTES];
    logic [7:0]           rd_data_reg;
    logic [7:0]           lo_byte_reg;
    logic [FAT_IDX_W-1:0] idx_lo;
    logic [FAT_IDX_W-1:0] idx_hi;
    logic [FAT_IDX_W-1:0] rd_idx;
    logic                 lo_out;
    logic                 hi_out;
    logic [15:0]          entry_word;
    logic [CLUSTER_W-1:0] entry;

    // item fields
    opcode_t              op;
    logic [FAT_AW-1:0]    in_addr;
    logic [7:0]           in_byte;
    logic [CLUSTER_W-1:0] in_cluster;

    // arithmetic
    logic [LBA_W-1:0]     clus_off;
    logic [LBA_W+7:0]     prod_full;
    logic [LBA_W-1:0]     prod_reg;

    // result and output registers
    resp_status_t         res_status_reg;
    logic [LBA_W-1:0]     res_lba_reg;
    logic                 m_valid_reg;
    resp_status_t         m_status_reg;
    logic [LBA_W-1:0]     m_lba_reg;
    logic                 out_free;

    // unpack the item
    assign op         = opcode_t'(s_tuser);
    assign in_addr    = s_tdata[12:0];
    assign in_byte    = s_tdata[20:13];
    assign in_cluster = s_tdata[32:21];

    // sector step and end test
    assign sic_inc = {1'b0, sic_reg} + 1'b1;
    assign wrap    = sic_inc >= {1'b0, spc_reg};
    assign pos_inc = pos_reg + 1'b1;
    assign pos_end = pos_reg >= LBA_W'(END_MARK);

    // fat entry at byte cluster*3/2
    assign idx_lo     = {2'b00, pos_reg[CLUSTER_W-1:0]} + {3'b000, pos_reg[CLUSTER_W-1:1]};
    assign idx_hi     = idx_lo + 1'b1;
    assign rd_idx     = cmd.fat_rd1 ? idx_hi : idx_lo;
    assign lo_out     = 32'(idx_lo) >= 32'(FAT_BYTES);
    assign hi_out     = 32'(idx_hi) >= 32'(FAT_BYTES);
    assign entry_word = {(hi_out ? 8'h00 : rd_data_reg), (lo_out ? 8'h00 : lo_byte_reg)};
    assign entry      = pos_reg[0] ? entry_word[15:4] : CLUSTER_W'(entry_word & ENTRY_MASK);

    // root length dividend, rounded up
    assign dividend = DIV_W'({root_entries_reg, 5'b00000}) + DIV_W'(bps_reg) - 1'b1;

    // cluster offset product
    assign clus_off  = pos_reg - LBA_W'(2);
    assign prod_full = clus_off * spc_reg;

    assign out_free = !m_valid_reg || m_tready;

    fccw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.calc_start),
        .dividend (dividend),
        .divisor  (bps_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg     <= RST_RESERVED_SECTORS;
            spf_reg          <= RST_SECTORS_PER_FAT;
            copies_reg       <= RST_FAT_COPIES;
            root_entries_reg <= RST_ROOT_ENTRIES;
            bps_reg          <= RST_BYTES_PER_SECTOR;
            spc_reg          <= RST_SECTORS_PER_CLUS;
            dirty_reg        <= 1'b1;
            pos_reg          <= '0;
            sic_reg          <= '0;
            root_mode_reg    <= 1'b0;
            chain_ended_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            // register writes
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_wr_index))
                    CFG_RESERVED_SECTORS: reserved_reg     <= cfg_wr_data;
                    CFG_SECTORS_PER_FAT:  spf_reg          <= cfg_wr_data;
                    CFG_FAT_COPIES:       copies_reg       <= cfg_wr_data[7:0];
                    CFG_ROOT_ENTRIES:     root_entries_reg <= cfg_wr_data;
                    CFG_BYTES_PER_SECTOR: bps_reg          <= cfg_wr_data[12:0];
                    CFG_SECTORS_PER_CLUS: spc_reg          <= cfg_wr_data[7:0];
                    default: ;
                endcase
            end

            // derived values go stale on any write
            if (cfg_wr_en) begin
                dirty_reg <= 1'b1;
            end else if (cmd.calc_start) begin
                dirty_reg <= 1'b0;
            end

            // item entry updates
            if (cmd.accept) begin
                unique case (op)
                    OP_LOAD: begin
                        pos_reg <= pos_reg;
                    end
                    OP_OPEN_FILE: begin
                        pos_reg         <= LBA_W'(in_cluster);
                        sic_reg         <= '0;
                        root_mode_reg   <= 1'b0;
                        chain_ended_reg <= 1'b0;
                    end
                    OP_OPEN_ROOT: begin
                        pos_reg         <= root_lba_reg;
                        sic_reg         <= '0;
                        root_mode_reg   <= 1'b1;
                        chain_ended_reg <= 1'b0;
                    end
                    OP_ADVANCE: begin
                        priority if (root_mode_reg) begin
                            pos_reg <= pos_inc;
                        end else if (!chain_ended_reg) begin
                            sic_reg <= wrap ? '0 : sic_inc[SECTOR_W-1:0];
                        end
                    end
                    default: pos_reg <= pos_reg;
                endcase
            end

            // follow the chain and test its end
            if (cmd.entry_take) begin
                pos_reg <= LBA_W'(entry);
            end
            if (cmd.end_check && pos_end) begin
                chain_ended_reg <= 1'b1;
            end

            // output register handshake
            if (cmd.resp_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // fat store write and read
    always_ff @(posedge aclk) begin
        if (cmd.accept && op == OP_LOAD && 32'(in_addr) < 32'(FAT_BYTES)) begin
            fat_mem[in_addr] <= in_byte;
        end
        if (cmd.fat_rd0 || cmd.fat_rd1) begin
            rd_data_reg <= fat_mem[rd_idx[FAT_AW-1:0]];
        end
        if (cmd.fat_rd1) begin
            lo_byte_reg <= rd_data_reg;
        end
    end

    // derived lba and result arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.calc_start) begin
            fat_mul_reg <= spf_reg * copies_reg;
        end
        if (cmd.calc_root) begin
            root_lba_reg <= LBA_W'(reserved_reg) + LBA_W'(fat_mul_reg);
        end
        if (cmd.calc_data) begin
            data_lba_reg <= root_lba_reg + LBA_W'(quotient);
        end
        if (cmd.mul_take) begin
            prod_reg <= prod_full[LBA_W-1:0];
        end

        if (cmd.accept) begin
            unique case (op)
                OP_LOAD: begin
                    res_status_reg <= RS_LOADED;
                    res_lba_reg    <= '0;
                end
                OP_OPEN_FILE: begin
                    res_status_reg <= RS_SECTOR;
                    res_lba_reg    <= '0;
                end
                OP_OPEN_ROOT: begin
                    res_status_reg <= RS_SECTOR;
                    res_lba_reg    <= root_lba_reg;
                end
                OP_ADVANCE: begin
                    res_status_reg <= root_mode_reg ? RS_SECTOR : RS_END;
                    res_lba_reg    <= root_mode_reg ? pos_inc : '0;
                end
                default: begin
                    res_status_reg <= RS_LOADED;
                    res_lba_reg    <= '0;
                end
            endcase
        end
        if (cmd.end_check && pos_end) begin
            res_status_reg <= RS_END;
            res_lba_reg    <= '0;
        end
        if (cmd.sum_take) begin
            res_status_reg <= RS_SECTOR;
            res_lba_reg    <= data_lba_reg + prod_reg + LBA_W'(sic_reg);
        end

        if (cmd.resp_load) begin
            m_status_reg <= res_status_reg;
            m_lba_reg    <= res_lba_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_lba_reg;

    assign sts.dirty       = dirty_reg;
    assign sts.wrap        = wrap;
    assign sts.root_mode   = root_mode_reg;
    assign sts.chain_ended = chain_ended_reg;
    assign sts.pos_end     = pos_end;
    assign sts.div_done    = div_done;
    assign sts.out_free    = out_free;

    // checks
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.resp_load |-> out_free)
        else $error("result overwrote a held item");
    a_modes_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(root_mode_reg && chain_ended_reg))
        else $error("chain ended while in root mode");
    a_file_cluster_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        !root_mode_reg |-> pos_reg[LBA_W-1:CLUSTER_W] == '0)
        else $error("file cluster wider than a fat12 entry");
    a_end_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_ended_reg && !(cmd.accept && (op == OP_OPEN_FILE || op == OP_OPEN_ROOT))
        |=> chain_ended_reg)
        else $error("chain end cleared without an open");

endmodule

`default_nettype wire

FILE: rtl/fat12_cluster_chain_sector_walker.sv
// top level of the fat12 cluster chain sector walker
//
// Items enter on the s_ stream: s_tuser carries the operation (load fat byte,
// open file chain, open root directory, advance one sector), s_tdata the
// fat byte address, fat byte and first cluster. Each item gives exactly one
// result on the m_ stream: m_tuser is the status, m_tdata the sector lba.
// Geometry registers are written through cfg_wr_en / cfg_wr_index /
// cfg_wr_data; the user must write them only while the block is idle, which
// the block itself does not enforce. One item is worked at a time. A load,
// open root, root advance or advance after the chain end loads its result at
// once; an open file does the offset multiply and the lba add; an advance
// inside a cluster tests the chain end, one that crosses into the next cluster
// does two fat store reads first, and both then do the multiply and the add
// unless the chain ends. s_tready returns the cycle after the result is loaded
// if no register write is pending. After reset and after any register
// write the root and data lba are recomputed before the next item is taken, by
// the one-bit-per-cycle divider that rounds up the root directory length. A
// stalled m_tready holds the result in the output register; the next item is
// still taken and waits in its last step until that slot frees.
`default_nettype none

module fat12_cluster_chain_sector_walker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration writes
    input  wire logic                            cfg_wr_en,
    input  wire logic [fccw_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [fccw_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // item input
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // fat_byte_address[12:0], fat_byte[20:13], first_cluster[32:21], zero pad
    input  wire logic [fccw_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  wire logic [fccw_pkg::S_TUSER_W-1:0]  s_tuser,
    // result output
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // sector_lba[31:0]
    output logic [fccw_pkg::M_TDATA_W-1:0]       m_tdata,
    // status[1:0]
    output logic [fccw_pkg::M_TUSER_W-1:0]       m_tuser
);
    import fccw_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    fccw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fccw_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire
